### rtl/core/time_of_day_counter_with_trim_unit_defines.svh
// ----------------------------------------------------------------------------
// time-of-day counter assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_COUNTER_WITH_TRIM_UNIT_DEFINES_SVH
`define TIME_OF_DAY_COUNTER_WITH_TRIM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdc check failed");
// next-cycle implication
`define TDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdc check failed");
`else
`define TDC_ASSERT_NOW(label, ante, cons)
`define TDC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg
// shared types and codes of the time-of-day counter
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned WrW    = 2;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [CountW-1:0] count_t;
  typedef logic [ModeW-1:0]  mode_t;
  typedef logic [WrW-1:0]    rtc_wr_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // command modes
  localparam mode_t MODE_TICK      = 3'd0;
  localparam mode_t MODE_HOUR_UP   = 3'd1;
  localparam mode_t MODE_HOUR_DOWN = 3'd2;
  localparam mode_t MODE_MIN_UP    = 3'd3;
  localparam mode_t MODE_CLR_SEC   = 3'd4;

  // external clock write requests
  localparam rtc_wr_t RTC_NONE  = 2'd0;
  localparam rtc_wr_t RTC_HOURS = 2'd1;
  localparam rtc_wr_t RTC_MINS  = 2'd2;
  localparam rtc_wr_t RTC_SECS  = 2'd3;

  // register indexes
  localparam cfg_idx_t REG_TICKS_PER_SEC = 3'd0;
  localparam cfg_idx_t REG_SECS_PER_MIN  = 3'd1;
  localparam cfg_idx_t REG_MINS_PER_HOUR = 3'd2;
  localparam cfg_idx_t REG_HOURS_PER_DAY = 3'd3;
  localparam cfg_idx_t REG_METRIC_DIV    = 3'd4;

  // register reset values
  localparam count_t RST_TICKS_PER_SEC = 8'd128;
  localparam count_t RST_SECS_PER_MIN  = 8'd60;
  localparam count_t RST_MINS_PER_HOUR = 8'd60;
  localparam count_t RST_HOURS_PER_DAY = 8'd24;
  localparam count_t RST_METRIC_DIV    = 8'd1;

  // remainder unit status
  typedef struct packed {
    logic busy;
    logic done;
  } rem_sts_t;

endpackage

### rtl/core/tdc_if.sv
// ----------------------------------------------------------------------------
// tdc channel interfaces
// command and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface tdc_cmd_if import tdc_pkg::*; ();
  logic   valid;
  logic   ready;
  mode_t  mode;
  count_t rtc_seconds;

  modport source (output valid, output mode, output rtc_seconds, input ready);
  modport sink   (input valid, input mode, input rtc_seconds, output ready);
endinterface

interface tdc_rsp_if import tdc_pkg::*; ();
  logic    valid;
  logic    ready;
  count_t  hours;
  count_t  minutes;
  count_t  seconds;
  logic    metric_pulse;
  logic    hourly_save;
  rtc_wr_t rtc_write;

  modport source (output valid, output hours, output minutes, output seconds,
                  output metric_pulse, output hourly_save, output rtc_write,
                  input ready);
  modport sink   (input valid, input hours, input minutes, input seconds,
                  input metric_pulse, input hourly_save, input rtc_write,
                  output ready);
endinterface

### rtl/core/tdc_rem.sv
// ----------------------------------------------------------------------------
// tdc_rem
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tdc_rem import tdc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  count_t   dividend,
  input  count_t   divisor,
  output rem_sts_t sts,
  output count_t   remainder
);

  localparam int unsigned StepW = $clog2(CountW);

  count_t             rem;
  count_t             shift;
  count_t             dsr;
  logic [StepW-1:0]   step;
  logic               busy;
  logic               done;
  logic [CountW:0]    part;
  logic [CountW:0]    diff;

  // partial remainder with next dividend bit, trial subtract
  assign part = {rem, shift[CountW-1]};
  assign diff = part - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= StepW'(CountW - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shift <= dividend;
      dsr   <= divisor;
    end else if (busy) begin
      shift <= {shift[CountW-2:0], 1'b0};
      if (part >= {1'b0, dsr}) begin
        rem <= diff[CountW-1:0];
      end else begin
        rem <= part[CountW-1:0];
      end
    end
  end

  assign sts       = '{busy: busy, done: done};
  assign remainder = rem;

endmodule

### rtl/core/time_of_day_counter_with_trim_unit.sv
// ----------------------------------------------------------------------------
// time_of_day_counter_with_trim_unit
// tick/second/minute/hour counter with set commands and rate trim
// ----------------------------------------------------------------------------
// usage:
//   cmd carries one command beat (mode, rtc_seconds); rsp returns exactly one
//   result beat per command with the counts after the command, the metric and
//   hourly save pulses, and the external clock write request.
//   cfg_we/cfg_index/cfg_data write the five limit registers; write only
//   while the block is idle (no command outstanding).
// sequence:
//   after a command is taken the remainder unit computes seconds mod
//   metric_divider, one bit per cycle; its registered done flag moves the
//   sequencer to the apply state, which updates the counters and loads the
//   result register.
//   cmd.ready is high only while idle, which the sequencer enters after the
//   apply: a new command is taken only after the last one has been applied.
// stall:
//   a held result does not block the next command; if the result register
//   is still full when a command reaches its apply cycle, the apply waits
//   (counters untouched) until rsp takes the old beat.
// reset:
//   counts clear to zero, limit registers load 128/60/60/24/1, rsp empty.
// ----------------------------------------------------------------------------
`include "time_of_day_counter_with_trim_unit_defines.svh"

module time_of_day_counter_with_trim_unit import tdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tdc_cmd_if.sink    cmd,
  tdc_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_index,
  input  count_t     cfg_data
);

  // sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // limit registers
  count_t ticks_per_second;
  count_t seconds_per_minute;
  count_t minutes_per_hour;
  count_t hours_per_day;
  count_t metric_divider;

  // time counters
  count_t tick_count;
  count_t second_count;
  count_t minute_count;
  count_t hour_count;
  count_t tick_next;
  count_t second_next;
  count_t minute_next;
  count_t hour_next;

  // captured command
  mode_t  mode_q;
  count_t rtc_q;

  // step outputs
  logic    pulse_next;
  logic    save_next;
  rtc_wr_t wr_next;

  rem_sts_t rem_sts;
  count_t   rem_val;

  logic cmd_fire;
  logic out_free;
  logic apply;

  count_t tick_inc;
  count_t sec_inc;
  count_t min_inc;
  count_t hour_inc;
  count_t hour_dec;
  count_t hour_wrap;

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign apply     = (state == ST_APPLY) && out_free;

  // seconds mod metric_divider, remainder unit
  tdc_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd_fire),
    .dividend  (second_count),
    .divisor   (metric_divider),
    .sts       (rem_sts),
    .remainder (rem_val)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second   <= RST_TICKS_PER_SEC;
      seconds_per_minute <= RST_SECS_PER_MIN;
      minutes_per_hour   <= RST_MINS_PER_HOUR;
      hours_per_day      <= RST_HOURS_PER_DAY;
      metric_divider     <= RST_METRIC_DIV;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICKS_PER_SEC: ticks_per_second   <= cfg_data;
        REG_SECS_PER_MIN:  seconds_per_minute <= cfg_data;
        REG_MINS_PER_HOUR: minutes_per_hour   <= cfg_data;
        REG_HOURS_PER_DAY: hours_per_day      <= cfg_data;
        REG_METRIC_DIV:    metric_divider     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (cmd_fire) state_next = ST_DIV;
      ST_DIV:   if (rem_sts.done) state_next = ST_APPLY;
      ST_APPLY: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      mode_q <= cmd.mode;
      rtc_q  <= cmd.rtc_seconds;
    end
  end

  // increments wrap at 8 bits before the limit compare
  assign tick_inc  = tick_count + 1'b1;
  assign sec_inc   = second_count + 1'b1;
  assign min_inc   = minute_count + 1'b1;
  assign hour_inc  = hour_count + 1'b1;
  assign hour_dec  = hour_count - 1'b1;
  assign hour_wrap = (hour_inc >= hours_per_day) ? '0 : hour_inc;

  // counter update for the captured command
  always_comb begin
    tick_next   = tick_count;
    second_next = second_count;
    minute_next = minute_count;
    hour_next   = hour_count;
    pulse_next  = 1'b0;
    save_next   = 1'b0;
    wr_next     = RTC_NONE;
    unique case (mode_q)
      MODE_TICK: begin
        tick_next = tick_inc;
        if (tick_inc == ticks_per_second) begin
          tick_next  = '0;
          pulse_next = (metric_divider == '0) || (rem_val == '0);
          second_next = sec_inc;
          if (sec_inc >= seconds_per_minute) begin
            second_next = '0;
            // trim: reading past half a minute means the local clock is fast
            if (rtc_q != '0) begin
              if (rtc_q > (seconds_per_minute >> 1)) begin
                tick_next = '1;
              end else begin
                tick_next = count_t'(1);
              end
            end
            minute_next = min_inc;
            if (min_inc >= minutes_per_hour) begin
              minute_next = '0;
              save_next   = 1'b1;
              hour_next   = hour_wrap;
            end
          end
        end
      end
      MODE_HOUR_UP: begin
        hour_next = hour_wrap;
        wr_next   = RTC_HOURS;
      end
      MODE_HOUR_DOWN: begin
        hour_next = (hour_dec >= hours_per_day) ? (hours_per_day - 1'b1) : hour_dec;
        wr_next   = RTC_HOURS;
      end
      MODE_MIN_UP: begin
        minute_next = (min_inc >= minutes_per_hour) ? '0 : min_inc;
        wr_next     = RTC_MINS;
      end
      MODE_CLR_SEC: begin
        second_next = '0;
        tick_next   = '0;
        wr_next     = RTC_SECS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      second_count <= '0;
      minute_count <= '0;
      hour_count   <= '0;
    end else if (apply) begin
      tick_count   <= tick_next;
      second_count <= second_next;
      minute_count <= minute_next;
      hour_count   <= hour_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (apply) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      rsp.hours        <= hour_next;
      rsp.minutes      <= minute_next;
      rsp.seconds      <= second_next;
      rsp.metric_pulse <= pulse_next;
      rsp.hourly_save  <= save_next;
      rsp.rtc_write    <= wr_next;
    end
  end

  // checks
  `TDC_ASSERT_NEXT(a_accept_starts_div, cmd.valid && cmd.ready, state == ST_DIV)
  `TDC_ASSERT_NOW(a_done_only_in_div, rem_sts.done, state == ST_DIV && !rem_sts.busy)
  `TDC_ASSERT_NOW(a_pulse_no_write, rsp.valid && (rsp.metric_pulse || rsp.hourly_save),
                  rsp.rtc_write == RTC_NONE)
  `TDC_ASSERT_NEXT(a_apply_loads_out, state == ST_APPLY && out_free, rsp.valid && state == ST_IDLE)

endmodule
